### design/sawm_pkg.sv
package sawm_pkg;

    localparam int NUM_BINS        = 26;
    localparam int BIN_W           = 5;
    localparam int START_W         = 16;
    localparam int AGREE_W         = 5;
    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_INDEX_BITS  = 16;

    localparam logic [1:0] FUNC_RESTART = 2'd0;
    localparam logic [1:0] FUNC_PATTERN = 2'd1;
    localparam logic [1:0] FUNC_TEXT    = 2'd2;

    localparam logic [AGREE_W-1:0] AGREE_ALL = AGREE_W'(NUM_BINS);

    typedef struct packed {
        logic [1:0]       func;
        logic [BIN_W-1:0] letter;
    } in_item_t;

    typedef struct packed {
        logic               match;
        logic [START_W-1:0] start_index;
        logic               window_full;
        logic               error;
    } out_item_t;

    // Per-item control decided at the input, carried down the pipeline.
    typedef struct packed {
        logic               restart;
        logic               add_act;
        logic               add_dec;
        logic [BIN_W-1:0]   add_bin;
        logic               rem_req;
        logic               match_en;
        logic               full;
        logic [START_W-1:0] start_index;
        logic               error;
    } front_t;

endpackage

### design/sawm_ring.sv
module sawm_ring #(
    parameter int DEPTH  = sawm_pkg::DEF_MAX_PATTERN,
    parameter int ADDR_W = 6
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [sawm_pkg::BIN_W-1:0] wdata,
    output logic [sawm_pkg::BIN_W-1:0] rdata
);

    logic [sawm_pkg::BIN_W-1:0] mem [DEPTH];
    logic [sawm_pkg::BIN_W-1:0] rdata_reg;

    // Read-first: the evicted letter comes out while the new one goes in.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/sawm_bank.sv
module sawm_bank #(
    parameter int CNT_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [sawm_pkg::BIN_W-1:0] raddr0,
    input  logic [sawm_pkg::BIN_W-1:0] raddr1,
    input  logic                       clear,
    input  logic                       we,
    input  logic [sawm_pkg::BIN_W-1:0] waddr,
    input  logic [CNT_W-1:0]           wdata,
    output logic [CNT_W-1:0]           rdata0,
    output logic [CNT_W-1:0]           rdata1
);

    logic [CNT_W-1:0]                mem [sawm_pkg::NUM_BINS];
    logic [sawm_pkg::NUM_BINS-1:0]   vld_reg;
    logic [CNT_W-1:0]                rd0_reg;
    logic [CNT_W-1:0]                rd1_reg;
    logic                            vld0_reg;
    logic                            vld1_reg;
    logic [sawm_pkg::BIN_W-1:0]      raddr0_reg;
    logic [sawm_pkg::BIN_W-1:0]      raddr1_reg;
    logic                            byp_we_reg;
    logic                            clr_reg;
    logic [sawm_pkg::BIN_W-1:0]      byp_addr_reg;
    logic [CNT_W-1:0]                byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            byp_we_reg <= 1'b0;
            clr_reg    <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                byp_we_reg <= we;
                clr_reg    <= clear;
            end
        end
    end

    // Capture the write and clear of the read edge so the reader sees them.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg      <= mem[raddr0];
            rd1_reg      <= mem[raddr1];
            vld0_reg     <= vld_reg[raddr0];
            vld1_reg     <= vld_reg[raddr1];
            raddr0_reg   <= raddr0;
            raddr1_reg   <= raddr1;
            byp_addr_reg <= waddr;
            byp_data_reg <= wdata;
        end
    end

    always_comb
    begin
        if (clr_reg)
        begin
            rdata0 = '0;
        end
        else if (byp_we_reg && (byp_addr_reg == raddr0_reg))
        begin
            rdata0 = byp_data_reg;
        end
        else if (vld0_reg)
        begin
            rdata0 = rd0_reg;
        end
        else
        begin
            rdata0 = '0;
        end

        if (clr_reg)
        begin
            rdata1 = '0;
        end
        else if (byp_we_reg && (byp_addr_reg == raddr1_reg))
        begin
            rdata1 = byp_data_reg;
        end
        else if (vld1_reg)
        begin
            rdata1 = rd1_reg;
        end
        else
        begin
            rdata1 = '0;
        end
    end

endmodule

### design/sawm_front.sv
module sawm_front #(
    parameter int MAX_PATTERN = sawm_pkg::DEF_MAX_PATTERN,
    parameter int INDEX_BITS  = sawm_pkg::DEF_INDEX_BITS
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    accept,
    input  sawm_pkg::in_item_t                                      item,
    output sawm_pkg::front_t                                        front,
    output logic                                                    ring_we,
    output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] ring_addr
);

    localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      ptr_next;
    logic [LEN_W-1:0]      plen_reg;
    logic [LEN_W-1:0]      plen_next;
    logic [LEN_W-1:0]      fill_reg;
    logic [LEN_W-1:0]      fill_next;
    logic [INDEX_BITS-1:0] pos_reg;
    logic [INDEX_BITS-1:0] pos_next;
    logic                  started_reg;
    logic                  started_next;
    logic [LEN_W:0]        slot_inc;
    logic                  slot_wrap;
    logic                  letter_ok;
    logic [INDEX_BITS+sawm_pkg::START_W-1:0] pos_ext;

    assign ring_addr = ptr_reg;
    assign slot_inc  = (LEN_W + 1)'(ptr_reg) + (LEN_W + 1)'(1);
    assign slot_wrap = slot_inc >= {1'b0, plen_reg};
    assign letter_ok = item.letter < sawm_pkg::BIN_W'(sawm_pkg::NUM_BINS);

    always_comb
    begin
        ptr_next       = ptr_reg;
        plen_next      = plen_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        ring_we        = 1'b0;
        front          = '0;
        front.match_en = 1'b1;

        case (item.func)
            sawm_pkg::FUNC_RESTART:
            begin
                ptr_next      = '0;
                plen_next     = '0;
                fill_next     = '0;
                pos_next      = '0;
                started_next  = 1'b0;
                front.restart = 1'b1;
            end
            sawm_pkg::FUNC_PATTERN:
            begin
                if (started_reg || (plen_reg == LEN_W'(MAX_PATTERN)) || !letter_ok)
                begin
                    front.error = 1'b1;
                end
                else
                begin
                    plen_next     = plen_reg + LEN_W'(1);
                    front.add_act = 1'b1;
                    front.add_dec = 1'b1;
                    front.add_bin = item.letter;
                end
            end
            sawm_pkg::FUNC_TEXT:
            begin
                started_next = 1'b1;
                if (plen_reg != '0)
                begin
                    ring_we = 1'b1;
                    if (fill_reg < plen_reg)
                    begin
                        fill_next = fill_reg + LEN_W'(1);
                    end
                    else
                    begin
                        front.rem_req = 1'b1;
                        pos_next      = pos_reg + INDEX_BITS'(1);
                    end
                    front.add_act = letter_ok;
                    front.add_bin = letter_ok ? item.letter : '0;
                    ptr_next      = slot_wrap ? '0 : slot_inc[PTR_W-1:0];
                end
            end
            default:
            begin
                front.match_en = 1'b0;
            end
        endcase

        pos_ext           = {{sawm_pkg::START_W{1'b0}}, pos_next};
        front.full        = (plen_next != '0) && (fill_next == plen_next);
        front.start_index = front.full ? pos_ext[sawm_pkg::START_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            plen_reg    <= '0;
            fill_reg    <= '0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
        end
        else if (accept)
        begin
            ptr_reg     <= ptr_next;
            plen_reg    <= plen_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
        end
    end

endmodule

### design/sliding_anagram_window_match_core.sv
// Sliding-window anagram matcher.
// Input channel item_valid/item_ready/item carries a func code and a letter:
// restart, pattern letter or text letter. Every accepted item yields exactly
// one result on result_valid/result_ready/result, in order: match,
// start_index of the current window, window_full and error.
// The ring is read at the accepting edge, then the histogram banks are read,
// then the result register is loaded and the result becomes valid.
// Throughput: one item per cycle while the receiver takes results;
// the window letter ring and the two histogram banks are each
// accessed once per item, with same-bin updates of adjacent items forwarded.
// The histograms hold window-minus-pattern counts in two 26-entry banks,
// one written on the added letter and one on the evicted letter.
// Reset: all state is clear right after rst_n is released; histogram entries
// read as zero through per-bin valid flags, so there is no clearing pass.
// A restart item clears the same state in order with the stream.
// When the receiver stalls, the result holds and up to three items stay in
// the pipeline; item_ready drops once all stages are full.
module sliding_anagram_window_match_core #(
    parameter int MAX_PATTERN = sawm_pkg::DEF_MAX_PATTERN,
    parameter int INDEX_BITS  = sawm_pkg::DEF_INDEX_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sawm_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output sawm_pkg::out_item_t result
);

    localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W = LEN_W + 1;

    logic                        accept;
    logic                        s1_adv;
    logic                        s2_adv;
    sawm_pkg::front_t            front;
    logic                        ring_we;
    logic [PTR_W-1:0]            ring_addr;
    logic [sawm_pkg::BIN_W-1:0]  ring_rdata;

    logic                        s1_valid_reg;
    sawm_pkg::front_t            s1_reg;
    logic                        s1_rem_act;
    logic [sawm_pkg::BIN_W-1:0]  s1_rem_bin;

    logic                        s2_valid_reg;
    sawm_pkg::front_t            s2_reg;
    logic                        s2_rem_act_reg;
    logic [sawm_pkg::BIN_W-1:0]  s2_rem_bin_reg;

    logic                        out_valid_reg;
    sawm_pkg::out_item_t         out_reg;
    sawm_pkg::out_item_t         out_next;

    logic [sawm_pkg::AGREE_W-1:0] agree_reg;
    logic [sawm_pkg::AGREE_W-1:0] agree_next;

    logic [CNT_W-1:0] a0, a1, r0, r1;
    logic [CNT_W-1:0] add_step;
    logic [CNT_W-1:0] a_wdata;
    logic [CNT_W-1:0] r_wdata;
    logic [CNT_W-1:0] d_add, d_add_new, d_rem, d_rem_new;
    logic             same_bin;
    logic             add_in, add_out, rem_in, rem_out;
    logic             bank_clear;

    assign s2_adv     = s2_valid_reg && (!out_valid_reg || result_ready);
    assign s1_adv     = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign item_ready = !s1_valid_reg || s1_adv;
    assign accept     = item_valid && item_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    sawm_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_BITS  (INDEX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .front     (front),
        .ring_we   (ring_we),
        .ring_addr (ring_addr)
    );

    sawm_ring #(
        .DEPTH  (MAX_PATTERN),
        .ADDR_W (PTR_W)
    ) u_ring (
        .clk   (clk),
        .en    (accept),
        .we    (ring_we),
        .addr  (ring_addr),
        .wdata (item.letter),
        .rdata (ring_rdata)
    );

    // Evicted letters outside the alphabet count in no bin.
    assign s1_rem_act = s1_reg.rem_req &&
                        (ring_rdata < sawm_pkg::BIN_W'(sawm_pkg::NUM_BINS));
    assign s1_rem_bin = s1_rem_act ? ring_rdata : '0;

    assign bank_clear = s2_adv && s2_reg.restart;
    assign add_step   = s2_reg.add_dec ? {CNT_W{1'b1}} : CNT_W'(1);
    assign a_wdata    = a0 + add_step;
    assign r_wdata    = r1 + CNT_W'(1);

    sawm_bank #(
        .CNT_W (CNT_W)
    ) u_bank_add (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (s1_adv),
        .raddr0 (s1_reg.add_bin),
        .raddr1 (s1_rem_bin),
        .clear  (bank_clear),
        .we     (s2_adv && s2_reg.add_act),
        .waddr  (s2_reg.add_bin),
        .wdata  (a_wdata),
        .rdata0 (a0),
        .rdata1 (a1)
    );

    sawm_bank #(
        .CNT_W (CNT_W)
    ) u_bank_rem (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (s1_adv),
        .raddr0 (s1_reg.add_bin),
        .raddr1 (s1_rem_bin),
        .clear  (bank_clear),
        .we     (s2_adv && s2_rem_act_reg),
        .waddr  (s2_rem_bin_reg),
        .wdata  (r_wdata),
        .rdata0 (r0),
        .rdata1 (r1)
    );

    // Bin difference is window minus pattern; zero means the bin agrees.
    always_comb
    begin
        d_add     = a0 - r0;
        d_add_new = d_add + add_step;
        d_rem     = a1 - r1;
        d_rem_new = d_rem - CNT_W'(1);
        same_bin  = s2_reg.add_act && s2_rem_act_reg && (s2_reg.add_bin == s2_rem_bin_reg);

        add_in  = s2_reg.add_act && !same_bin && (d_add != '0) && (d_add_new == '0);
        add_out = s2_reg.add_act && !same_bin && (d_add == '0) && (d_add_new != '0);
        rem_in  = s2_rem_act_reg && !same_bin && (d_rem != '0) && (d_rem_new == '0);
        rem_out = s2_rem_act_reg && !same_bin && (d_rem == '0) && (d_rem_new != '0);

        if (s2_reg.restart)
        begin
            agree_next = sawm_pkg::AGREE_ALL;
        end
        else
        begin
            agree_next = agree_reg + sawm_pkg::AGREE_W'(add_in) + sawm_pkg::AGREE_W'(rem_in)
                       - sawm_pkg::AGREE_W'(add_out) - sawm_pkg::AGREE_W'(rem_out);
        end

        out_next.match       = s2_reg.match_en && s2_reg.full &&
                               (agree_next == sawm_pkg::AGREE_ALL);
        out_next.start_index = s2_reg.start_index;
        out_next.window_full = s2_reg.full;
        out_next.error       = s2_reg.error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            agree_reg     <= sawm_pkg::AGREE_ALL;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
                agree_reg     <= agree_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= front;
        end
        if (s1_adv)
        begin
            s2_reg         <= s1_reg;
            s2_rem_act_reg <= s1_rem_act;
            s2_rem_bin_reg <= s1_rem_bin;
        end
        if (s2_adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### tb/sliding_anagram_window_match_core_tb.sv
module sliding_anagram_window_match_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PATTERN  = sawm_pkg::DEF_MAX_PATTERN;
    localparam int NUM_BINS     = sawm_pkg::NUM_BINS;
    localparam int CYCLE_LIMIT  = 50_000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [1:0] F_RESTART = sawm_pkg::FUNC_RESTART;
    localparam logic [1:0] F_PATTERN = sawm_pkg::FUNC_PATTERN;
    localparam logic [1:0] F_TEXT    = sawm_pkg::FUNC_TEXT;

    // Selector value that the block must ignore.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        sawm_pkg::in_item_t  stim;
        logic                typed;
        sawm_pkg::out_item_t res;
    } dir_row_t;

    localparam sawm_pkg::out_item_t ALL_ZERO    = '{1'b0, 16'd0, 1'b0, 1'b0};
    localparam sawm_pkg::out_item_t PAT_FLAGGED = '{1'b0, 16'd0, 1'b0, 1'b1};

    localparam int NUM_DIRECTED = 22;
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{'{F_RESTART,   5'd0},  1'b1, ALL_ZERO},
        '{'{F_TEXT,      5'd31}, 1'b1, ALL_ZERO},     // text with empty pattern
        '{'{F_PATTERN,   5'd0},  1'b1, PAT_FLAGGED},  // late pattern letter
        '{'{FUNC_UNUSED, 5'd31}, 1'b1, ALL_ZERO},
        '{'{F_RESTART,   5'd0},  1'b1, ALL_ZERO},
        '{'{F_PATTERN,   5'd0},  1'b1, ALL_ZERO},
        '{'{F_PATTERN,   5'd25}, 1'b1, ALL_ZERO},
        '{'{F_PATTERN,   5'd31}, 1'b1, PAT_FLAGGED},  // bad pattern code
        '{'{F_PATTERN,   5'd26}, 1'b1, PAT_FLAGGED},
        '{'{F_TEXT,      5'd25}, 1'b0, ALL_ZERO},
        '{'{F_TEXT,      5'd0},  1'b0, ALL_ZERO},
        '{'{F_TEXT,      5'd25}, 1'b0, ALL_ZERO},
        '{'{F_TEXT,      5'd31}, 1'b0, ALL_ZERO},     // bad text code takes a slot
        '{'{F_TEXT,      5'd0},  1'b0, ALL_ZERO},
        '{'{FUNC_UNUSED, 5'd10}, 1'b0, ALL_ZERO},
        '{'{F_TEXT,      5'd25}, 1'b0, ALL_ZERO},
        '{'{F_PATTERN,   5'd0},  1'b0, ALL_ZERO},     // late, on a full window
        '{'{F_RESTART,   5'd0},  1'b1, ALL_ZERO},
        '{'{F_PATTERN,   5'd10}, 1'b1, ALL_ZERO},
        '{'{F_TEXT,      5'd10}, 1'b0, ALL_ZERO},
        '{'{F_TEXT,      5'd21}, 1'b0, ALL_ZERO},
        '{'{F_TEXT,      5'd10}, 1'b0, ALL_ZERO}
    };

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    sawm_pkg::in_item_t  item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    sawm_pkg::out_item_t result;

    sliding_anagram_window_match_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: histograms, agree count, letter ring and positions.
    int          pat_count [NUM_BINS];
    int          win_count [NUM_BINS];
    int          bins_agree;
    logic [4:0]  ring_letters [MAX_PATTERN];
    int          ring_ptr;
    int          pat_len;
    int          win_fill;
    logic [15:0] text_pos;
    bit          text_seen;

    sawm_pkg::out_item_t expected_results [$];
    sawm_pkg::out_item_t want;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_left;
    int cycle_count;
    int seq_no;
    int items_sent;
    int results_checked;
    int matches_seen;
    int flagged_seen;
    int mismatches;

    function automatic void clear_histograms();
        for (int b = 0; b < NUM_BINS; b++)
        begin
            pat_count[b] = 0;
            win_count[b] = 0;
        end
        bins_agree = NUM_BINS;
        ring_ptr   = 0;
        pat_len    = 0;
        win_fill   = 0;
        text_pos   = '0;
        text_seen  = 1'b0;
    endfunction

    // Move one bin of one histogram and keep the agree count in step.
    function automatic void adjust_bin(input bit in_window, input logic [4:0] bin,
                                       input bit add);
        bit was_equal;
        bit now_equal;
        if (bin >= NUM_BINS)
            return;
        was_equal = (pat_count[bin] == win_count[bin]);
        if (in_window)
            win_count[bin] += add ? 1 : -1;
        else
            pat_count[bin] += add ? 1 : -1;
        now_equal = (pat_count[bin] == win_count[bin]);
        if (was_equal && !now_equal)
            bins_agree--;
        else if (!was_equal && now_equal)
            bins_agree++;
    endfunction

    function automatic sawm_pkg::out_item_t predict_result(input sawm_pkg::in_item_t it);
        sawm_pkg::out_item_t r;
        bit                  full;
        int                  slot;
        r = '0;
        case (it.func)
            F_RESTART: clear_histograms();
            F_PATTERN:
            begin
                if (text_seen || pat_len >= MAX_PATTERN || it.letter >= NUM_BINS)
                    r.error = 1'b1;
                else
                begin
                    adjust_bin(1'b0, it.letter, 1'b1);
                    pat_len++;
                end
            end
            F_TEXT:
            begin
                text_seen = 1'b1;
                if (pat_len != 0)
                begin
                    slot = ring_ptr;
                    if (win_fill < pat_len)
                        win_fill++;
                    else
                    begin
                        // evict the oldest letter and advance the window start
                        adjust_bin(1'b1, ring_letters[slot], 1'b0);
                        text_pos = text_pos + 16'd1;
                    end
                    ring_letters[slot] = it.letter;
                    adjust_bin(1'b1, it.letter, 1'b1);
                    slot++;
                    ring_ptr = (slot >= pat_len) ? 0 : slot;
                end
            end
            default: ;
        endcase
        full = (pat_len != 0) && (win_fill == pat_len);
        r.match       = (it.func != FUNC_UNUSED) && full && (bins_agree == NUM_BINS);
        r.start_index = full ? text_pos : 16'd0;
        r.window_full = full;
        return r;
    endfunction

    task automatic send_item(input sawm_pkg::in_item_t it, input bit typed,
                             input sawm_pkg::out_item_t typed_res);
        sawm_pkg::out_item_t pred;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pred = predict_result(it);
        expected_results.insert(expected_results.size(), typed ? typed_res : pred);
        items_sent++;
    endtask

    task automatic send_plain(input logic [1:0] f, input logic [4:0] l);
        send_item('{f, l}, 1'b0, ALL_ZERO);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Sequences of restart, pattern and text with random content, plus noise.
    task automatic run_random(input int n_items);
        int first;
        int plen;
        int tlen;
        int base;
        int span;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            seq_no++;
            if ($urandom_range(0, 9) != 0)
                send_plain(F_RESTART, 5'($urandom_range(0, 31)));
            if (seq_no % 25 == 12)
                plen = MAX_PATTERN + $urandom_range(1, 3);
            else if ($urandom_range(0, 11) == 0)
                plen = 0;
            else
                plen = $urandom_range(1, 6);
            base = $urandom_range(0, 23);
            span = $urandom_range(1, 3);
            for (int k = 0; k < plen; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_plain(F_PATTERN, 5'($urandom_range(26, 31)));
                else
                    send_plain(F_PATTERN, 5'($urandom_range(base, base + span - 1)));
            end
            if (plen > 6)
                tlen = MAX_PATTERN + $urandom_range(1, 30);
            else
                tlen = $urandom_range(plen, plen * 4 + 6);
            for (int k = 0; k < tlen; k++)
            begin
                case ($urandom_range(0, 49))
                    0, 1: send_plain(F_TEXT, 5'($urandom_range(26, 31)));
                    2: send_plain(F_PATTERN, 5'($urandom_range(0, 31)));
                    3: send_plain(FUNC_UNUSED, 5'($urandom_range(0, 31)));
                    4: send_plain(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
                    default: send_plain(F_TEXT, 5'($urandom_range(base, base + span - 1)));
                endcase
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: %p", result);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (result.match)
                    matches_seen++;
                if (result.error)
                    flagged_seen++;
                if (result.match !== want.match)
                begin
                    $error("match expected %0d actual %0d", want.match, result.match);
                    mismatches++;
                end
                if (result.start_index !== want.start_index)
                begin
                    $error("start_index expected %0d actual %0d",
                           want.start_index, result.start_index);
                    mismatches++;
                end
                if (result.window_full !== want.window_full)
                begin
                    $error("window_full expected %0d actual %0d",
                           want.window_full, result.window_full);
                    mismatches++;
                end
                if (result.error !== want.error)
                begin
                    $error("error expected %0d actual %0d", want.error, result.error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sliding_anagram_window_match_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        clear_histograms();
        send_idle_pct  = 26;
        recv_stall_pct = 48;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].res);
        run_random(500);

        // hold the sender until every result is back, then stall the receiver long
        wait_drained();
        hold_req = 1'b1;
        send_idle_pct  = 48;
        recv_stall_pct = 26;
        run_random(520);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(500);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d items and %0d results: %0d matches, %0d flagged",
                 items_sent, results_checked, matches_seen, flagged_seen);
        $display("three idling mixes, a long receiver hold-off and a full drain");
        if (mismatches == 0)
            $display("sliding_anagram_window_match_core_tb: PASS");
        else
            $display("sliding_anagram_window_match_core_tb: FAIL");
        $finish;
    end

endmodule
